// File: hdl/mspfp_pkg.sv
`default_nettype none
package mspfp_pkg;

	// Header bytes of a request frame.
	localparam logic [7:0] HDR_DOLLAR = 8'h24; // '$'
	localparam logic [7:0] HDR_M      = 8'h4D; // 'M'
	localparam logic [7:0] HDR_LT     = 8'h3C; // '<'

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd0;
	localparam logic [1:0] REG_REQUEST_LOW  = 2'd1;
	localparam logic [1:0] REG_REQUEST_HIGH = 2'd2;

	// Register values after reset.
	localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd100;
	localparam logic [7:0] REQUEST_LOW_RST  = 8'd100;
	localparam logic [7:0] REQUEST_HIGH_RST = 8'd254;

	// Command and checksum bytes come on top of the payload size.
	localparam logic [8:0] BODY_EXTRA = 9'd2;

	typedef struct packed {
		logic [7:0] max_payload;
		logic [7:0] request_low;
		logic [7:0] request_high;
	} cfg_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [8:0] byte_index;
		logic       is_command;
		logic       last_byte;
		logic       checksum_ok;
		logic       is_request;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/mspfp_cfg_regs.sv
`default_nettype none
module mspfp_cfg_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output      mspfp_pkg::cfg_t   cfg
);

	mspfp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// An index past the last register is taken and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload  <= mspfp_pkg::MAX_PAYLOAD_RST;
			cfg_q.request_low  <= mspfp_pkg::REQUEST_LOW_RST;
			cfg_q.request_high <= mspfp_pkg::REQUEST_HIGH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mspfp_pkg::REG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data;
				mspfp_pkg::REG_REQUEST_LOW:  cfg_q.request_low  <= cfg_data;
				mspfp_pkg::REG_REQUEST_HIGH: cfg_q.request_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/mspfp_in_stage.sv
`default_nettype none
module mspfp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output      logic       s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       advance,
	output      logic       valid_s1,
	output      logic [7:0] byte_s1
);

	// The held byte leaves whenever the parser takes it, so a new one may
	// enter in the same cycle.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule
`default_nettype wire

// File: hdl/mspfp_parser.sv
`default_nettype none
module mspfp_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mspfp_pkg::cfg_t      cfg,
	input  wire logic                 valid_s1,
	input  wire logic [7:0]           byte_s1,
	output      logic                 advance,
	output      logic                 res_valid,
	input  wire logic                 res_ready,
	output      mspfp_pkg::result_t   res
);

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_DOLLAR = 3'd1;
	localparam logic [2:0] PH_M      = 3'd2;
	localparam logic [2:0] PH_SIZE   = 3'd3;
	localparam logic [2:0] PH_BODY   = 3'd4;

	logic [2:0]         phase_q;
	logic [8:0]         bytes_left_q;
	logic [8:0]         store_index_q;
	logic [7:0]         running_xor_q;
	logic [7:0]         held_command_q;
	logic               res_valid_q;
	mspfp_pkg::result_t res_q;

	logic               fire;
	logic               in_body;
	logic               first;
	logic               last;
	logic [7:0]         cmd;
	mspfp_pkg::result_t res_d;

	assign advance   = !res_valid_q || res_ready;
	assign fire      = valid_s1 && advance;
	assign in_body   = (phase_q == PH_BODY);
	assign first     = (store_index_q == '0);
	assign last      = (bytes_left_q[8:1] == '0);
	assign cmd       = first ? byte_s1 : held_command_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		res_d.frame_byte  = byte_s1;
		res_d.byte_index  = store_index_q;
		res_d.is_command  = first;
		res_d.last_byte   = last;
		res_d.checksum_ok = last && (running_xor_q == byte_s1);
		res_d.is_request  = last && (cfg.request_low <= cmd) && (cmd <= cfg.request_high);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			bytes_left_q   <= '0;
			store_index_q  <= '0;
			running_xor_q  <= '0;
			held_command_q <= '0;
		end else if (fire) begin
			case (phase_q)
				PH_DOLLAR: phase_q <= (byte_s1 == mspfp_pkg::HDR_M) ? PH_M : PH_HUNT;
				PH_M:      phase_q <= (byte_s1 == mspfp_pkg::HDR_LT) ? PH_SIZE : PH_HUNT;
				PH_SIZE: begin
					if (byte_s1 > cfg.max_payload) begin
						phase_q <= PH_HUNT;
					end else begin
						phase_q       <= PH_BODY;
						bytes_left_q  <= {1'b0, byte_s1} + mspfp_pkg::BODY_EXTRA;
						store_index_q <= '0;
						running_xor_q <= byte_s1;
					end
				end
				PH_BODY: begin
					if (first) begin
						held_command_q <= byte_s1;
					end
					if (last) begin
						phase_q      <= PH_HUNT;
						bytes_left_q <= '0;
					end else begin
						running_xor_q <= running_xor_q ^ byte_s1;
						bytes_left_q  <= bytes_left_q - 9'd1;
					end
					store_index_q <= store_index_q + 9'd1;
				end
				default: phase_q <= (byte_s1 == mspfp_pkg::HDR_DOLLAR) ? PH_DOLLAR : PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && in_body;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_body) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_body_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_body |-> (bytes_left_q != '0))
		else $error("frame body entered with no bytes left");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && in_body && last) |=> (phase_q == PH_HUNT))
		else $error("parser did not return to hunting after the checksum byte");

	a_command_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.is_command == (res_q.byte_index == '0)))
		else $error("command flag does not match position zero");

	a_verdicts_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.last_byte) |-> (!res_q.checksum_ok && !res_q.is_request))
		else $error("frame verdicts set on a byte that is not the last");
`endif

endmodule
`default_nettype wire

// File: hdl/msp_request_frame_parser.sv
`default_nettype none
// Receive-side parser for request frames of the MultiWii serial protocol,
// version 1. Each request on the input stream is one received serial byte.
// The parser hunts for the header '$','M','<' and then reads the size byte;
// a size above max_payload drops the frame silently and hunting restarts,
// as does any unexpected header byte (that byte is not rechecked as a new
// '$'). The command byte, the payload bytes and the checksum byte each leave
// as one output request carrying the byte, its position after the size
// byte (0 for the command) and the command flag; header and size bytes give
// no output. The checksum byte is marked with tlast and carries two verdicts:
// whether the XOR of size, command and payload equals it, and whether the
// command lies within request_low..request_high (an empty range gives 0).
// Throughput is one byte per clock while the output is not stalled: a byte
// is held in the input register and is parsed by short logic into the
// output register, from which its output request leaves. Both registers
// advance together whenever the output register is empty or being drained.
// Configuration writes take effect on the next cycle and should only be
// made while no frame is in flight.
module msp_request_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,   // 0 max_payload, 1 request_low, 2 request_high
	input  wire logic [7:0]  cfg_data,

	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte

	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,     // [7:0] frame_byte, [16:8] byte_index,
	                                      // [17] checksum_ok, [18] is_request, rest zero
	output      logic        m_tuser,     // [0] is_command
	output      logic        m_tlast      // last_byte: checksum byte of the frame
);

	mspfp_pkg::cfg_t    cfg;
	mspfp_pkg::result_t res;
	logic               advance;
	logic               valid_s1;
	logic [7:0]         byte_s1;

	mspfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mspfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mspfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Verdicts ride in tdata above the byte and its position.
	assign m_tdata = {5'b0, res.is_request, res.checksum_ok, res.byte_index, res.frame_byte};
	assign m_tuser = res.is_command;
	assign m_tlast = res.last_byte;

endmodule
`default_nettype wire

// File: dv/tb_msp_request_frame_parser.sv
`default_nettype none
// Checks the request frame parser against a cycle-free model of its byte
// parsing. A driver streams serial bytes from a queue, a monitor drains the
// output stream and compares every output request with the oldest predicted
// frame byte. The run walks through several register settings and three
// idling patterns on the two stream sides.
module tb_msp_request_frame_parser;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Phases of the header hunt, as the parser steps through a frame.
	typedef enum logic [2:0] {
		SEEK_DOLLAR = 3'd0,
		SEEN_DOLLAR = 3'd1,
		SEEN_M      = 3'd2,
		READ_SIZE   = 3'd3,
		IN_BODY     = 3'd4
	} parse_phase_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = mspfp_pkg::REG_MAX_PAYLOAD;
	logic [7:0]  cfg_data  = 8'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;            // [7:0] frame_byte, [16:8] byte_index,
	                                 // [17] checksum_ok, [18] is_request
	logic        m_tuser;            // [0] is_command
	logic        m_tlast;            // last_byte

	msp_request_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Bytes waiting to be sent, and frame bytes predicted but not yet seen.
	logic [7:0]         rx_stream[$];
	mspfp_pkg::result_t frame_bytes_due[$];
	int                 rx_pushed = 0;
	int                 errors = 0;

	// Percent of cycles in which the sender holds back or the receiver stalls.
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;

	// Register copies and parser state of the prediction.
	logic [7:0]   lim_payload = mspfp_pkg::MAX_PAYLOAD_RST;
	logic [7:0]   req_lo      = mspfp_pkg::REQUEST_LOW_RST;
	logic [7:0]   req_hi      = mspfp_pkg::REQUEST_HIGH_RST;
	parse_phase_t phase       = SEEK_DOLLAR;
	logic [8:0]   body_left   = 9'd0;
	logic [8:0]   body_pos    = 9'd0;
	logic [7:0]   xor_acc     = 8'd0;
	logic [7:0]   cur_cmd     = 8'd0;

	// Advances the parser by one received byte and queues the frame byte it
	// gives out, if any. Header and size bytes produce nothing.
	function automatic void parse_rx_byte(input logic [7:0] b);
		mspfp_pkg::result_t r;
		logic               fin;
		case (phase)
			SEEN_DOLLAR: phase = (b == mspfp_pkg::HDR_M) ? SEEN_M : SEEK_DOLLAR;
			SEEN_M:      phase = (b == mspfp_pkg::HDR_LT) ? READ_SIZE : SEEK_DOLLAR;
			READ_SIZE: begin
				if (b > lim_payload) begin
					phase = SEEK_DOLLAR;
				end else begin
					phase     = IN_BODY;
					body_left = {1'b0, b} + mspfp_pkg::BODY_EXTRA;
					body_pos  = 9'd0;
					xor_acc   = b;
				end
			end
			IN_BODY: begin
				fin = (body_left <= 9'd1);
				if (body_pos == 9'd0) begin
					cur_cmd = b;
				end
				r.frame_byte  = b;
				r.byte_index  = body_pos;
				r.is_command  = (body_pos == 9'd0);
				r.last_byte   = fin;
				r.checksum_ok = 1'b0;
				r.is_request  = 1'b0;
				if (fin) begin
					// The checksum byte closes the frame and carries both verdicts.
					r.checksum_ok = (xor_acc == b);
					r.is_request  = (req_lo <= cur_cmd) && (cur_cmd <= req_hi);
					phase         = SEEK_DOLLAR;
					body_left     = 9'd0;
				end else begin
					xor_acc   = xor_acc ^ b;
					body_left = body_left - 9'd1;
				end
				body_pos = body_pos + 9'd1;
				frame_bytes_due.push_back(r);
			end
			default: phase = (b == mspfp_pkg::HDR_DOLLAR) ? SEEN_DOLLAR : SEEK_DOLLAR;
		endcase
	endfunction

	// Sender: a byte counts as taken at an edge where valid and ready are high.
	// The next byte goes out only if the current one is gone or none was up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_rx_byte(s_tdata);
			end
			if (!s_tvalid || s_tready) begin
				if (rx_stream.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					s_tdata  <= rx_stream.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: every output request is matched against the oldest prediction.
	mspfp_pkg::result_t got;
	mspfp_pkg::result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.frame_byte  = m_tdata[7:0];
				got.byte_index  = m_tdata[16:8];
				got.checksum_ok = m_tdata[17];
				got.is_request  = m_tdata[18];
				got.is_command  = m_tuser;
				got.last_byte   = m_tlast;
				if (frame_bytes_due.size() == 0) begin
					$display("%0t: unexpected output: expected nothing, got %p", $time, got);
					errors++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (got.frame_byte !== want.frame_byte ||
					    got.byte_index !== want.byte_index ||
					    got.is_command !== want.is_command ||
					    got.last_byte !== want.last_byte ||
					    got.checksum_ok !== want.checksum_ok ||
					    got.is_request !== want.is_request ||
					    m_tdata[23:19] !== 5'd0) begin
						$display("%0t: mismatch: expected %p, got %p (tdata %h)",
							$time, want, got, m_tdata);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	function automatic void push_rx(input logic [7:0] b);
		rx_stream.push_back(b);
		rx_pushed++;
	endfunction

	// Queues a complete request frame with random payload. A bad checksum is
	// made by flipping at least one bit of the correct one.
	function automatic void push_frame(input logic [7:0] size, input logic [7:0] cmd,
			input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] pay;
		sum = size ^ cmd;
		push_rx(mspfp_pkg::HDR_DOLLAR);
		push_rx(mspfp_pkg::HDR_M);
		push_rx(mspfp_pkg::HDR_LT);
		push_rx(size);
		push_rx(cmd);
		for (int i = 0; i < size; i++) begin
			pay = 8'($urandom);
			sum = sum ^ pay;
			push_rx(pay);
		end
		if (bad_sum) begin
			sum = sum ^ 8'($urandom_range(255, 1));
		end
		push_rx(sum);
	endfunction

	// Returns once every byte has been sent and every frame byte has come out.
	// A further wait covers header and size bytes still inside the parser.
	task automatic wait_idle();
		do @(negedge clk);
		while (rx_stream.size() != 0 || s_tvalid || frame_bytes_due.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			mspfp_pkg::REG_MAX_PAYLOAD:  lim_payload = val;
			mspfp_pkg::REG_REQUEST_LOW:  req_lo      = val;
			mspfp_pkg::REG_REQUEST_HIGH: req_hi      = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Mostly well-formed frames with small random sizes, commands near the
	// edges of the request range and some bad checksums, mixed with oversized
	// frames, broken headers and line noise.
	task automatic feed_random(input int n_bytes);
		int         goal;
		int         pick;
		int         cap;
		logic [7:0] size;
		logic [7:0] cmd;
		logic [7:0] junk;
		goal = rx_pushed + n_bytes;
		while (rx_pushed < goal) begin
			pick = $urandom_range(99, 0);
			if (pick < 70 || (pick < 80 && lim_payload == 8'd255)) begin
				cap = (lim_payload < 8'd12) ? int'(lim_payload) : 12;
				if ($urandom_range(99, 0) < 4) begin
					size = lim_payload;
				end else begin
					size = 8'($urandom_range(cap, 0));
				end
				case ($urandom_range(7, 0))
					0:       cmd = req_lo - 8'd1;
					1:       cmd = req_lo;
					2:       cmd = req_hi;
					3:       cmd = req_hi + 8'd1;
					default: cmd = 8'($urandom);
				endcase
				push_frame(size, cmd, $urandom_range(99, 0) < 15);
			end else if (pick < 80) begin
				push_rx(mspfp_pkg::HDR_DOLLAR);
				push_rx(mspfp_pkg::HDR_M);
				push_rx(mspfp_pkg::HDR_LT);
				push_rx(8'($urandom_range(255, int'(lim_payload) + 1)));
			end else if (pick < 90) begin
				// Header broken after the dollar sign or after the 'M'.
				junk = 8'($urandom);
				push_rx(mspfp_pkg::HDR_DOLLAR);
				if ($urandom_range(1, 0)) begin
					push_rx((junk == mspfp_pkg::HDR_M) ? (junk ^ 8'h01) : junk);
				end else begin
					push_rx(mspfp_pkg::HDR_M);
					push_rx((junk == mspfp_pkg::HDR_LT) ? (junk ^ 8'h01) : junk);
				end
			end else begin
				repeat ($urandom_range(4, 1)) push_rx(8'($urandom));
			end
		end
		wait_idle();
	endtask

	initial begin
		int guard;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset settings. The sender waits for each
		// frame to drain completely before starting the next one.
		send_gap_pct   = 26;
		recv_stall_pct = 77;
		// A second dollar sign after the first is not taken as a new start,
		// so this header leads nowhere.
		push_rx(mspfp_pkg::HDR_DOLLAR);
		push_rx(mspfp_pkg::HDR_DOLLAR);
		push_rx(mspfp_pkg::HDR_M);
		push_rx(mspfp_pkg::HDR_LT);
		wait_idle();
		// One above the size limit: dropped without output.
		push_rx(mspfp_pkg::HDR_DOLLAR);
		push_rx(mspfp_pkg::HDR_M);
		push_rx(mspfp_pkg::HDR_LT);
		push_rx(mspfp_pkg::MAX_PAYLOAD_RST + 8'd1);
		wait_idle();
		// Zero size: command byte then checksum, command at the low bound.
		push_frame(8'd0, mspfp_pkg::REQUEST_LOW_RST, 1'b0);
		wait_idle();
		push_frame(8'd1, 8'd255, 1'b1);
		wait_idle();
		push_frame(8'd2, mspfp_pkg::REQUEST_LOW_RST - 8'd1, 1'b0);
		wait_idle();

		feed_random(220);

		// Widest settings, one frame of the largest size, and a write to the
		// unused index that must leave all registers alone.
		write_reg(mspfp_pkg::REG_MAX_PAYLOAD, 8'd255);
		write_reg(mspfp_pkg::REG_REQUEST_LOW, 8'd0);
		write_reg(mspfp_pkg::REG_REQUEST_HIGH, 8'd255);
		write_reg(REG_SPARE, 8'd0);
		push_frame(8'd255, 8'($urandom), 1'b0);
		feed_random(220);

		// Receiver now mostly ready, sender mostly idle.
		send_gap_pct   = 77;
		recv_stall_pct = 26;
		write_reg(mspfp_pkg::REG_MAX_PAYLOAD, 8'd0);
		write_reg(mspfp_pkg::REG_REQUEST_LOW, 8'd255);
		write_reg(mspfp_pkg::REG_REQUEST_HIGH, 8'd255);
		feed_random(220);

		// An empty request range: no command may count as a request.
		write_reg(mspfp_pkg::REG_MAX_PAYLOAD, 8'd20);
		write_reg(mspfp_pkg::REG_REQUEST_LOW, 8'd200);
		write_reg(mspfp_pkg::REG_REQUEST_HIGH, 8'd50);
		feed_random(220);

		// Full throughput on both sides.
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		write_reg(mspfp_pkg::REG_MAX_PAYLOAD, 8'($urandom_range(40, 8)));
		write_reg(mspfp_pkg::REG_REQUEST_LOW, 8'($urandom));
		write_reg(mspfp_pkg::REG_REQUEST_HIGH, 8'($urandom));
		feed_random(220);

		write_reg(mspfp_pkg::REG_MAX_PAYLOAD, 8'd7);
		write_reg(mspfp_pkg::REG_REQUEST_LOW, 8'd0);
		write_reg(mspfp_pkg::REG_REQUEST_HIGH, 8'd0);
		feed_random(220);

		// Final drain with its own bound, so that missing output is reported
		// as such rather than as a hang.
		guard = 0;
		while ((rx_stream.size() != 0 || s_tvalid || frame_bytes_due.size() != 0) &&
		       guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (6) @(negedge clk);
		if (frame_bytes_due.size() != 0) begin
			$display("%0t: %0d frame bytes never came out, oldest expected %p",
				$time, frame_bytes_due.size(), frame_bytes_due[0]);
			errors++;
		end
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#600000;
		$display("%0t: run did not complete in time", $time);
		$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
